[hdl/fat_cluster_table_engine_macros.svh]
// Assertion macros shared by the cluster table engine RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef FAT_CLUSTER_TABLE_ENGINE_MACROS_SVH
`define FAT_CLUSTER_TABLE_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define FCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/fct_pkg.sv]
// Shared types and constants for the cluster table engine.
// No dependencies; used by fct_dpath, fct_ctrl and the top level.
package fct_pkg;

    localparam int TABLE_BYTES_DEF = 16384;

    // byte offsets of an entry reach 2*65536+1, kept in 18 bits
    localparam int OFS_W  = 18;
    localparam int CAND_W = 17;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX  = 1'd1;

    localparam logic        MODE_RST = 1'b1;
    localparam logic [15:0] MAX_RST  = 16'd2;

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_READ = 3'd1;
    localparam logic [2:0] OP_GET  = 3'd2;
    localparam logic [2:0] OP_SET  = 3'd3;
    localparam logic [2:0] OP_FIND = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef enum logic [2:0] {
        RES_OK,
        RES_NOSPACE,
        RES_RANGE,
        RES_BYTE,
        RES_ENTRY,
        RES_CAND
    } t_res;

    typedef struct packed {
        logic latch;      // take new operation fields
        logic rd;         // read both banks at current offset
        logic wr_byte;    // write one loaded byte
        logic wr_entry;   // write merged entry word
        logic link;       // entry data is the candidate, not the operand
        logic use_cand;   // address from candidate rather than cluster
        logic cand_init;
        logic cand_inc;
        logic res_en;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       byte_ok;
        logic       ent_ok;
        logic       clus_zero;
        logic       cand_gt_max;
        logic       free;
    } t_sts;

endpackage

[hdl/fat_cluster_table_engine.sv]
// Top level of the FAT12/FAT16 cluster table engine.
// Depends on fct_pkg, fct_ctrl, fct_dpath and fat_cluster_table_engine_macros.svh.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+------------------------------------------
//  command   | in        | start, busy          | i_opcode i_byte_address i_byte_data
//            |           |                      | i_cluster i_entry_value
//  result    | out       | o_done (1-cycle)     | o_value o_status
//  config    | in        | i_cfg_we             | i_cfg_index i_cfg_data
//
// Cycles: a beat is taken when start is high and busy is low. Load byte is decided in the
// cycle after the beat; read byte, get and set read both byte banks in that cycle and form the
// result in the next, where busy is already low again, so a new beat can be taken while the result is formed.
// Find free checks each candidate against the maximum and the store, then reads and compares
// its entry, moving on while it is in use; a nonzero operand cluster then has its entry read
// and rewritten to link the found candidate. The result stands on o_value/o_status for the
// single cycle o_done is high; the receiver cannot stall it.
// Reset (i_rst_n low at a clock edge) idles the controller, sets 12-bit mode and a maximum
// cluster of 2; the table contents are not cleared and must be loaded before they are read.
`include "fat_cluster_table_engine_macros.svh"

module fat_cluster_table_engine #(
    parameter int TABLE_BYTES = fct_pkg::TABLE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_opcode,
    input  logic [13:0]                   i_byte_address,
    input  logic [7:0]                    i_byte_data,
    input  logic [15:0]                   i_cluster,
    input  logic [15:0]                   i_entry_value,
    input  logic                          i_cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output logic                          o_done,
    output logic [15:0]                   o_value,
    output logic [1:0]                    o_status
);

    fct_pkg::t_cmd cmd;
    fct_pkg::t_sts sts;

    // sequencing only; no payload passes through the controller
    fct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // table banks, operand latches, candidate counter and result register
    fct_dpath #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_byte_address (i_byte_address),
        .i_byte_data    (i_byte_data),
        .i_cluster      (i_cluster),
        .i_entry_value  (i_entry_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_done         (o_done),
        .o_value        (o_value),
        .o_status       (o_status)
    );

    `FCT_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_done, (o_status == fct_pkg::ST_OK) || (o_status == fct_pkg::ST_NOSPACE) || (o_status == fct_pkg::ST_RANGE), "undefined status code")
    `FCT_ASSERT_IMP(a_fail_value_zero, i_clk, i_rst_n, o_done && (o_status != fct_pkg::ST_OK), o_value == 16'd0, "failed result carries a value")
    `FCT_ASSERT_NXT(a_beat_busy, i_clk, i_rst_n, start && !busy, busy, "accepted beat did not raise busy")

endmodule

[hdl/fct_dpath.sv]
// Datapath: config registers, operand latches, two byte banks, result register.
// Depends on fct_pkg; driven by fct_ctrl through t_cmd.
module fct_dpath #(
    parameter int TABLE_BYTES = fct_pkg::TABLE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    input  logic [2:0]                    i_opcode,
    input  logic [13:0]                   i_byte_address,
    input  logic [7:0]                    i_byte_data,
    input  logic [15:0]                   i_cluster,
    input  logic [15:0]                   i_entry_value,
    input  fct_pkg::t_cmd                 i_cmd,
    output fct_pkg::t_sts                 o_sts,
    output logic                          o_done,
    output logic [15:0]                   o_value,
    output logic [1:0]                    o_status
);

    // even bytes in one bank, odd bytes in the other: an entry pair is one row each
    localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
    localparam int ROW_W      = $clog2(BANK_DEPTH);
    localparam logic [fct_pkg::OFS_W-1:0] TB_LIM = fct_pkg::OFS_W'(TABLE_BYTES);

    logic [7:0] mem_even [BANK_DEPTH];
    logic [7:0] mem_odd  [BANK_DEPTH];

    logic                        r_mode;
    logic [15:0]                 r_max;
    logic [2:0]                  r_op;
    logic [13:0]                 r_addr;
    logic [7:0]                  r_data;
    logic [15:0]                 r_clus;
    logic [15:0]                 r_ev;
    logic [fct_pkg::CAND_W-1:0]  r_cand;
    logic                        r_lo_odd;
    logic                        r_c_odd;
    logic [7:0]                  r_even_q;
    logic [7:0]                  r_odd_q;
    logic                        r_done;
    logic [15:0]                 r_value;
    logic [1:0]                  r_status;

    logic                        byte_op;
    logic [fct_pkg::CAND_W-1:0]  c_sel;
    logic [fct_pkg::OFS_W-1:0]   ent_ofs;
    logic [fct_pkg::OFS_W-1:0]   ent_hi;
    logic [fct_pkg::OFS_W-1:0]   ofs;
    logic [fct_pkg::OFS_W-1:0]   ofs_hi;
    logic [ROW_W-1:0]            even_row;
    logic [ROW_W-1:0]            odd_row;
    logic [15:0]                 word;
    logic [15:0]                 ent_val;
    logic [15:0]                 x_val;
    logic [15:0]                 new_word;
    logic                        we_even;
    logic                        we_odd;
    logic [7:0]                  wd_even;
    logic [7:0]                  wd_odd;

    assign byte_op = (r_op == fct_pkg::OP_LOAD) || (r_op == fct_pkg::OP_READ);
    assign c_sel   = i_cmd.use_cand ? r_cand : {1'b0, r_clus};
    assign ent_ofs = {1'b0, c_sel} + (r_mode ? {2'b00, c_sel[fct_pkg::CAND_W-1:1]}
                                             : {1'b0, c_sel});
    assign ent_hi  = ent_ofs + fct_pkg::OFS_W'(1);
    assign ofs     = byte_op ? {4'd0, r_addr} : ent_ofs;
    assign ofs_hi  = ofs + fct_pkg::OFS_W'(1);

    // even-bank row is (ofs+1)/2 whether ofs is odd or even
    assign even_row = ofs_hi[ROW_W:1];
    assign odd_row  = ofs[ROW_W:1];

    assign word = r_lo_odd ? {r_even_q, r_odd_q} : {r_odd_q, r_even_q};

    always_comb begin
        if (!r_mode) begin
            ent_val = word;
        end else if (r_c_odd) begin
            ent_val = {4'd0, word[15:4]};
        end else begin
            ent_val = {4'd0, word[11:0]};
        end
    end

    assign x_val = i_cmd.link ? r_cand[15:0] : r_ev;

    // packed entries keep the neighbour's nibble
    always_comb begin
        if (!r_mode) begin
            new_word = x_val;
        end else if (c_sel[0]) begin
            new_word = {x_val[11:0], word[3:0]};
        end else begin
            new_word = {word[15:12], x_val[11:0]};
        end
    end

    always_comb begin
        we_even = i_cmd.wr_entry || (i_cmd.wr_byte && !ofs[0]);
        we_odd  = i_cmd.wr_entry || (i_cmd.wr_byte && ofs[0]);
        if (i_cmd.wr_byte) begin
            wd_even = r_data;
            wd_odd  = r_data;
        end else begin
            wd_even = ofs[0] ? new_word[15:8] : new_word[7:0];
            wd_odd  = ofs[0] ? new_word[7:0]  : new_word[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_even) begin
            mem_even[even_row] <= wd_even;
        end
        if (i_cmd.rd) begin
            r_even_q <= mem_even[even_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_odd) begin
            mem_odd[odd_row] <= wd_odd;
        end
        if (i_cmd.rd) begin
            r_odd_q <= mem_odd[odd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_lo_odd <= ofs[0];
            r_c_odd  <= c_sel[0];
        end
        if (i_cmd.latch) begin
            r_op   <= i_opcode;
            r_addr <= i_byte_address;
            r_data <= i_byte_data;
            r_clus <= i_cluster;
            r_ev   <= i_entry_value;
        end
        if (i_cmd.cand_init) begin
            r_cand <= (r_clus == 16'd0) ? fct_pkg::CAND_W'(2)
                                        : {1'b0, r_clus} + fct_pkg::CAND_W'(1);
        end else if (i_cmd.cand_inc) begin
            r_cand <= r_cand + fct_pkg::CAND_W'(1);
        end
        if (i_cmd.res_en) begin
            case (i_cmd.res)
                fct_pkg::RES_NOSPACE: begin
                    r_value  <= 16'd0;
                    r_status <= fct_pkg::ST_NOSPACE;
                end
                fct_pkg::RES_RANGE: begin
                    r_value  <= 16'd0;
                    r_status <= fct_pkg::ST_RANGE;
                end
                fct_pkg::RES_BYTE: begin
                    r_value  <= {8'd0, r_lo_odd ? r_odd_q : r_even_q};
                    r_status <= fct_pkg::ST_OK;
                end
                fct_pkg::RES_ENTRY: begin
                    r_value  <= ent_val;
                    r_status <= fct_pkg::ST_OK;
                end
                fct_pkg::RES_CAND: begin
                    r_value  <= r_cand[15:0];
                    r_status <= fct_pkg::ST_OK;
                end
                default: begin
                    r_value  <= 16'd0;
                    r_status <= fct_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= fct_pkg::MODE_RST;
            r_max  <= fct_pkg::MAX_RST;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.res_en;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fct_pkg::REG_MODE: r_mode <= i_cfg_data[0];
                    fct_pkg::REG_MAX:  r_max  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_sts.op          = r_op;
    assign o_sts.byte_ok     = {4'd0, r_addr} < TB_LIM;
    assign o_sts.ent_ok      = ent_hi < TB_LIM;
    assign o_sts.clus_zero   = (r_clus == 16'd0);
    assign o_sts.cand_gt_max = r_cand > {1'b0, r_max};
    assign o_sts.free        = (ent_val == 16'd0);

    assign o_done   = r_done;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

[hdl/fct_ctrl.sv]
// Controller state machine sequencing byte, entry and free-search operations.
// Depends on fct_pkg and fat_cluster_table_engine_macros.svh.
`include "fat_cluster_table_engine_macros.svh"

module fct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  fct_pkg::t_sts i_sts,
    output fct_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EVAL,
        S_CHK,
        S_SRCH,
        S_LRD,
        S_LWR
    } t_state;

    t_state        r_state;
    t_state        n_state;
    fct_pkg::t_cmd cmd;
    logic          accept;

    // the result-forming cycle takes the next beat
    assign o_busy = !((r_state == S_IDLE) || (r_state == S_EVAL));
    assign accept = i_start && !o_busy;

    always_comb begin
        n_state   = r_state;
        cmd       = '0;
        cmd.latch = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_sts.op) inside
                    fct_pkg::OP_LOAD: begin
                        cmd.res_en = 1'b1;
                        if (i_sts.byte_ok) begin
                            cmd.wr_byte = 1'b1;
                            cmd.res     = fct_pkg::RES_OK;
                        end else begin
                            cmd.res = fct_pkg::RES_RANGE;
                        end
                    end
                    fct_pkg::OP_READ: begin
                        if (i_sts.byte_ok) begin
                            cmd.rd  = 1'b1;
                            n_state = S_EVAL;
                        end else begin
                            cmd.res_en = 1'b1;
                            cmd.res    = fct_pkg::RES_RANGE;
                        end
                    end
                    fct_pkg::OP_GET, fct_pkg::OP_SET: begin
                        if (i_sts.ent_ok) begin
                            cmd.rd  = 1'b1;
                            n_state = S_EVAL;
                        end else begin
                            cmd.res_en = 1'b1;
                            cmd.res    = fct_pkg::RES_RANGE;
                        end
                    end
                    fct_pkg::OP_FIND: begin
                        if (!i_sts.clus_zero && !i_sts.ent_ok) begin
                            cmd.res_en = 1'b1;
                            cmd.res    = fct_pkg::RES_RANGE;
                        end else begin
                            cmd.cand_init = 1'b1;
                            n_state       = S_CHK;
                        end
                    end
                    default: begin
                        cmd.res_en = 1'b1;
                        cmd.res    = fct_pkg::RES_RANGE;
                    end
                endcase
            end
            S_EVAL: begin
                cmd.res_en = 1'b1;
                n_state    = accept ? S_EXEC : S_IDLE;
                unique case (i_sts.op) inside
                    fct_pkg::OP_READ: cmd.res = fct_pkg::RES_BYTE;
                    fct_pkg::OP_GET:  cmd.res = fct_pkg::RES_ENTRY;
                    fct_pkg::OP_SET: begin
                        cmd.wr_entry = 1'b1;
                        cmd.res      = fct_pkg::RES_OK;
                    end
                    default: cmd.res = fct_pkg::RES_RANGE;
                endcase
            end
            S_CHK: begin
                cmd.use_cand = 1'b1;
                if (i_sts.cand_gt_max) begin
                    cmd.res_en = 1'b1;
                    cmd.res    = fct_pkg::RES_NOSPACE;
                    n_state    = S_IDLE;
                end else if (!i_sts.ent_ok) begin
                    cmd.res_en = 1'b1;
                    cmd.res    = fct_pkg::RES_RANGE;
                    n_state    = S_IDLE;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                cmd.use_cand = 1'b1;
                if (!i_sts.free) begin
                    cmd.cand_inc = 1'b1;
                    n_state      = S_CHK;
                end else if (i_sts.clus_zero) begin
                    cmd.res_en = 1'b1;
                    cmd.res    = fct_pkg::RES_CAND;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_LRD;
                end
            end
            S_LRD: begin
                cmd.rd  = 1'b1;
                n_state = S_LWR;
            end
            S_LWR: begin
                cmd.wr_entry = 1'b1;
                cmd.link     = 1'b1;
                cmd.res_en   = 1'b1;
                cmd.res      = fct_pkg::RES_CAND;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

    `FCT_ASSERT_IMP(a_entry_wr_in_range, i_clk, i_rst_n, cmd.wr_entry, i_sts.ent_ok, "entry write outside the store")
    `FCT_ASSERT_IMP(a_byte_wr_in_range, i_clk, i_rst_n, cmd.wr_byte, i_sts.byte_ok, "byte write outside the store")
    `FCT_ASSERT_IMP(a_read_no_write, i_clk, i_rst_n, cmd.rd, !cmd.wr_entry && !cmd.wr_byte, "read and write in one cycle")
    `FCT_ASSERT_NXT(a_walk_on, i_clk, i_rst_n, (r_state == S_SRCH) && !i_sts.free, r_state == S_CHK, "busy entry did not advance the search")

endmodule
